FILE: design/ipv4dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4dq_pkg;

    // parser phase codes
    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_NEED   = 3'd2;
    localparam logic [2:0] PH_TRAIL  = 3'd3;
    localparam logic [2:0] PH_OK     = 3'd4;
    localparam logic [2:0] PH_FAIL   = 3'd5;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [1:0]  MAX_DIGITS = 2'd3;
    localparam logic [1:0]  LAST_OCTET = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  octet_index;
        logic [7:0]  octet_value;
        logic [1:0]  digit_count;
        logic [31:0] address_acc;
    } dq_state_t;

    localparam dq_state_t STATE_RESET = '{
        phase:       PH_LEAD,
        octet_index: 2'd0,
        octet_value: 8'd0,
        digit_count: 2'd0,
        address_acc: 32'd0
    };

endpackage

`default_nettype wire

FILE: design/ipv4dq_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4dq_step
(
    input  wire ipv4dq_pkg::dq_state_t cur,
    input  wire logic [7:0]            ch,
    output ipv4dq_pkg::dq_state_t      nxt
);
    import ipv4dq_pkg::*;

    logic        is_digit;
    logic        space_tab;
    logic        trail_ws;
    logic [11:0] grown;
    logic [31:0] acc_shifted;

    always_comb
    begin
        is_digit    = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT9);
        space_tab   = (ch == CH_SPACE) || (ch == CH_TAB);
        trail_ws    = space_tab || (ch == CH_CR) || (ch == CH_LF);
        // digit value is the low nibble for '0'..'9'
        grown       = 12'(cur.octet_value) * 12'd10 + 12'(ch[3:0]);
        acc_shifted = {cur.address_acc[23:0], cur.octet_value};
    end

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_LEAD, PH_NEED:
            begin
                if (is_digit)
                begin
                    nxt.octet_value = {4'd0, ch[3:0]};
                    nxt.digit_count = 2'd1;
                    nxt.phase       = PH_DIGITS;
                end
                else if (!(cur.phase == PH_LEAD && space_tab))
                begin
                    nxt.phase = PH_FAIL;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    if (cur.digit_count >= MAX_DIGITS || grown > OCTET_MAX)
                    begin
                        nxt.phase = PH_FAIL;
                    end
                    else
                    begin
                        nxt.octet_value = grown[7:0];
                        nxt.digit_count = cur.digit_count + 2'd1;
                    end
                end
                else if (cur.octet_index != LAST_OCTET)
                begin
                    if (ch == CH_DOT)
                    begin
                        nxt.address_acc = acc_shifted;
                        nxt.octet_index = cur.octet_index + 2'd1;
                        nxt.phase       = PH_NEED;
                    end
                    else
                    begin
                        nxt.phase = PH_FAIL;
                    end
                end
                else if (ch == CH_NUL)
                begin
                    nxt.address_acc = acc_shifted;
                    nxt.phase       = PH_OK;
                end
                else if (trail_ws)
                begin
                    nxt.address_acc = acc_shifted;
                    nxt.phase       = PH_TRAIL;
                end
                else
                begin
                    nxt.phase = PH_FAIL;
                end
            end
            PH_TRAIL:
            begin
                if (ch == CH_NUL)
                begin
                    nxt.phase = PH_OK;
                end
                else if (!trail_ws)
                begin
                    nxt.phase = PH_FAIL;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ipv4_dotted_quad_parser_unit.sv
// strict dotted-quad ipv4 address parser
// request channel: req_valid / req_stall carry one string byte (ch) per request,
// with last set on the final byte of a string
// result channel: res_valid / res_stall carry valid_res and address, one result
// per string, issued after the request marked last
// a request is taken into an input register at its accepting edge, then parsed and
// folded into the parser state when it leaves that register, which also loads the
// result register; res_valid rises when the last request leaves the input register
// throughput is one byte per cycle while no result waits under res_stall, set by the
// single state update between the input register and the result register
// while a result waits under res_stall, a byte sitting in the input register is
// held there and req_stall is raised until the result is taken
// reset clears the parser state and both valid flags; after each string the
// parser returns to its reset state by itself
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_quad_parser_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             valid_res,
    output logic [31:0]      address
);
    import ipv4dq_pkg::*;

    logic        req_valid_reg;
    logic        req_valid_next;
    logic [7:0]  ch_reg;
    logic        last_reg;
    dq_state_t   state_reg;
    dq_state_t   state_next;
    dq_state_t   st_byte;
    dq_state_t   st_term;
    dq_state_t   st_final;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        valid_res_reg;
    logic [31:0] address_reg;
    logic        advance;
    logic        fire;
    logic        accept;
    logic        done;

    ipv4dq_step u_step
    (
        .cur (state_reg),
        .ch  (ch_reg),
        .nxt (st_byte)
    );

    // end of string without a nul acts as one
    ipv4dq_step u_term
    (
        .cur (st_byte),
        .ch  (CH_NUL),
        .nxt (st_term)
    );

    always_comb
    begin
        advance   = !res_valid_reg || !res_stall;
        fire      = req_valid_reg && advance;
        req_stall = req_valid_reg && !advance;
        accept    = req_valid && !req_stall;
        done      = (st_byte.phase == PH_OK) || (st_byte.phase == PH_FAIL);
        st_final  = done ? st_byte : st_term;

        req_valid_next = accept ? 1'b1 : (fire ? 1'b0 : req_valid_reg);

        state_next = state_reg;
        if (fire)
        begin
            state_next = last_reg ? STATE_RESET : st_byte;
        end

        res_valid_next = res_valid_reg;
        if (fire && last_reg)
        begin
            res_valid_next = 1'b1;
        end
        else if (advance)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (fire && last_reg)
        begin
            valid_res_reg <= (st_final.phase == PH_OK);
            address_reg   <= (st_final.phase == PH_OK) ? st_final.address_acc : 32'd0;
        end
    end

    assign res_valid = res_valid_reg;
    assign valid_res = valid_res_reg;
    assign address   = address_reg;

endmodule

`default_nettype wire

FILE: design/ipv4dq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4dq_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        valid_res,
    input wire logic [31:0] address
);

    // a held result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(valid_res) && $stable(address))
        else $error("result changed while stalled");

    // an invalid string reports a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |-> address == 32'd0)
        else $error("invalid result with nonzero address");

    // requests are only held back by a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled without a waiting result");

    // with no result waiting, an offered request is always taken
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !res_valid |-> !req_stall)
        else $error("request stalled with no result waiting");

endmodule

bind ipv4_dotted_quad_parser_unit ipv4dq_checker u_ipv4dq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .valid_res (valid_res),
    .address   (address)
);

`default_nettype wire
